@@ rtl/gsl_pkg.sv @@
// Shared types and constants for the gapped slot list.
// No dependencies; imported by the controller, datapath and top level.
package gsl_pkg;

  // Operation codes carried in the opcode field
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_ACCESS = 2'd2;
  localparam logic [1:0] OP_FIND   = 2'd3;

  localparam logic [4:0] SIZE_RESET = 5'd16;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_POS_INC,
    IDX_POS_DEC,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    RA_POS,
    RA_IDX,
    RA_IDX_DEC,
    RA_IDX_INC
  } rd_sel_t;

  typedef enum logic {
    WA_POS,
    WA_IDX
  } wa_sel_t;

  typedef enum logic [1:0] {
    WD_ZERO,
    WD_VAL,
    WD_RD
  } wd_sel_t;

  typedef enum logic [1:0] {
    FILL_HOLD,
    FILL_INC,
    FILL_DEC
  } fill_op_t;

  // Controller to datapath
  typedef struct packed {
    logic     capture;
    idx_op_t  idx_op;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wa_sel_t  wa_sel;
    wd_sel_t  wd_sel;
    fill_op_t fill_op;
    logic     set_ok;
    logic     set_rd;
    logic     set_fp;
    logic     out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       pos_ok;
    logic       val_nz;
    logic       not_full;
    logic       pos_zero;
    logic       idx_at_end;
    logic       idx_zero;
    logic       idx_eq_pos;
    logic       rd_zero;
    logic       rd_match;
    logic       out_free;
  } dp_status_t;

endpackage

@@ rtl/gsl_if.sv @@
// Channel interfaces: request, response and size configuration.
// Standalone; valid/ready handshake with source and sink modports.
interface gsl_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [3:0] position;
  logic [7:0] value;
  modport source (output valid, output opcode, output position, output value, input ready);
  modport sink (input valid, input opcode, input position, input value, output ready);
endinterface

interface gsl_rsp_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic [7:0] read_value;
  logic [3:0] found_position;
  logic [4:0] filled_count;
  modport source (output valid, output ok, output read_value, output found_position,
                  output filled_count, input ready);
  modport sink (input valid, input ok, input read_value, input found_position,
                input filled_count, output ready);
endinterface

interface gsl_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/gsl_ctrl.sv @@
// Sequencer for the gapped slot list: one operation at a time.
// Depends on gsl_pkg for command and status types.
module gsl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gsl_pkg::dp_status_t st,
  output gsl_pkg::dp_cmd_t    cmd
);
  import gsl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_RA_CHK, S_INS_CHK,
    S_R_RD, S_R_CHK, S_SHR_RD, S_SHR_WR,
    S_L_RD, S_L_CHK, S_SHL_RD, S_SHL_WR,
    S_F_RD, S_F_CHK, S_FINISH
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.idx_op  = IDX_HOLD;
    cmd.rd_sel  = RA_IDX;
    cmd.wa_sel  = WA_IDX;
    cmd.wd_sel  = WD_RD;
    cmd.fill_op = FILL_HOLD;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        case (st.op)
          OP_INSERT: begin
            if (st.val_nz && st.pos_ok && st.not_full) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_POS;
              state_next = S_INS_CHK;
            end else begin
              state_next = S_FINISH;
            end
          end
          OP_REMOVE, OP_ACCESS: begin
            if (st.pos_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_POS;
              state_next = S_RA_CHK;
            end else begin
              state_next = S_FINISH;
            end
          end
          default: begin
            cmd.idx_op = IDX_ZERO;
            state_next = S_F_RD;
          end
        endcase
      end
      S_RA_CHK: begin
        if (!st.rd_zero) begin
          cmd.set_ok = 1'b1;
          if (st.op == OP_REMOVE) begin
            cmd.wr_en   = 1'b1;
            cmd.wa_sel  = WA_POS;
            cmd.wd_sel  = WD_ZERO;
            cmd.fill_op = FILL_DEC;
          end else begin
            cmd.set_rd = 1'b1;
          end
        end
        state_next = S_FINISH;
      end
      S_INS_CHK: begin
        if (st.rd_zero) begin
          cmd.wr_en   = 1'b1;
          cmd.wa_sel  = WA_POS;
          cmd.wd_sel  = WD_VAL;
          cmd.fill_op = FILL_INC;
          cmd.set_ok  = 1'b1;
          state_next  = S_FINISH;
        end else begin
          cmd.idx_op = IDX_POS_INC;
          state_next = S_R_RD;
        end
      end
      S_R_RD: begin
        if (st.idx_at_end) begin
          if (st.pos_zero) begin
            state_next = S_FINISH;
          end else begin
            cmd.idx_op = IDX_POS_DEC;
            state_next = S_L_RD;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_R_CHK;
        end
      end
      S_R_CHK: begin
        if (st.rd_zero) begin
          state_next = S_SHR_RD;
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_R_RD;
        end
      end
      S_SHR_RD, S_SHL_RD: begin
        if (st.idx_eq_pos) begin
          cmd.wr_en   = 1'b1;
          cmd.wa_sel  = WA_POS;
          cmd.wd_sel  = WD_VAL;
          cmd.fill_op = FILL_INC;
          cmd.set_ok  = 1'b1;
          state_next  = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = (state == S_SHR_RD) ? RA_IDX_DEC : RA_IDX_INC;
          state_next = (state == S_SHR_RD) ? S_SHR_WR : S_SHL_WR;
        end
      end
      S_SHR_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.idx_op = IDX_DEC;
        state_next = S_SHR_RD;
      end
      S_SHL_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.idx_op = IDX_INC;
        state_next = S_SHL_RD;
      end
      S_L_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_L_CHK;
      end
      S_L_CHK: begin
        if (st.rd_zero) begin
          state_next = S_SHL_RD;
        end else if (st.idx_zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.idx_op = IDX_DEC;
          state_next = S_L_RD;
        end
      end
      S_F_RD: begin
        if (st.idx_at_end) begin
          state_next = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_F_CHK;
        end
      end
      S_F_CHK: begin
        if (st.rd_match) begin
          cmd.set_ok = 1'b1;
          cmd.set_fp = 1'b1;
          state_next = S_FINISH;
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_F_RD;
        end
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/gsl_dp.sv @@
// Datapath: slot memory with valid bits, item capture, index walker,
// fill counter, size register and result/output registers. Uses gsl_pkg.
module gsl_dp #(
  parameter int SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_data,
  input  logic [1:0]          in_opcode,
  input  logic [3:0]          in_position,
  input  logic [7:0]          in_value,
  input  gsl_pkg::dp_cmd_t    cmd,
  output gsl_pkg::dp_status_t st,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_ok,
  output logic [7:0]          out_read_value,
  output logic [3:0]          out_found_position,
  output logic [4:0]          out_filled_count
);
  import gsl_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int SW = (CW > 5) ? CW : 5;

  logic [7:0]    mem [SLOTS];
  logic [SLOTS-1:0] valid;
  logic [7:0]    rd_data;

  logic [4:0]    size_cfg;
  logic [SW-1:0] size_eff;

  logic [1:0]    op;
  logic [3:0]    pos;
  logic [7:0]    val;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] filled;

  logic          res_ok;
  logic [7:0]    res_rd;
  logic [CW-1:0] res_fp;

  logic [AW-1:0] ra, wa;
  logic [7:0]    wd;

  // Size register, clamped to 1..SLOTS
  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg <= SIZE_RESET;
    end else if (cfg_we) begin
      size_cfg <= cfg_data;
    end
  end

  always_comb begin
    if (size_cfg == 5'd0) begin
      size_eff = SW'(1);
    end else if (SW'(size_cfg) > SW'(SLOTS)) begin
      size_eff = SW'(SLOTS);
    end else begin
      size_eff = SW'(size_cfg);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op  <= in_opcode;
      pos <= in_position;
      val <= in_value;
    end
  end

  always_comb begin
    case (cmd.idx_op)
      IDX_ZERO:    idx_next = '0;
      IDX_POS_INC: idx_next = CW'(pos) + CW'(1);
      IDX_POS_DEC: idx_next = CW'(pos) - CW'(1);
      IDX_INC:     idx_next = idx + CW'(1);
      IDX_DEC:     idx_next = idx - CW'(1);
      default:     idx_next = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
  end

  always_comb begin
    case (cmd.rd_sel)
      RA_POS:     ra = AW'(pos);
      RA_IDX_DEC: ra = AW'(idx - CW'(1));
      RA_IDX_INC: ra = AW'(idx + CW'(1));
      default:    ra = AW'(idx);
    endcase
    wa = (cmd.wa_sel == WA_POS) ? AW'(pos) : AW'(idx);
    case (cmd.wd_sel)
      WD_ZERO: wd = 8'd0;
      WD_VAL:  wd = val;
      default: wd = rd_data;
    endcase
  end

  // Slot store; an entry never written since reset reads as empty
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.wr_en) begin
      valid[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= valid[ra] ? mem[ra] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else begin
      case (cmd.fill_op)
        FILL_INC: filled <= filled + CW'(1);
        FILL_DEC: filled <= (filled == '0) ? '0 : filled - CW'(1);
        default:  filled <= filled;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_ok <= 1'b0;
      res_rd <= 8'd0;
      res_fp <= '0;
    end else begin
      if (cmd.set_ok) res_ok <= 1'b1;
      if (cmd.set_rd) res_rd <= rd_data;
      if (cmd.set_fp) res_fp <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ok             <= res_ok;
      out_read_value     <= res_rd;
      out_found_position <= 4'(res_fp);
      out_filled_count   <= 5'(filled);
    end
  end

  always_comb begin
    st.op         = op;
    st.pos_ok     = SW'(pos) < size_eff;
    st.val_nz     = (val != 8'd0);
    st.not_full   = SW'(filled) < size_eff;
    st.pos_zero   = (pos == 4'd0);
    st.idx_at_end = SW'(idx) >= size_eff;
    st.idx_zero   = (idx == '0);
    st.idx_eq_pos = (SW'(idx) == SW'(pos));
    st.rd_zero    = (rd_data == 8'd0);
    st.rd_match   = (rd_data == val);
    st.out_free   = !out_valid || out_ready;
  end

endmodule

@@ rtl/gapped_slot_list.sv @@
// Gapped slot list: one item at a time through a single-port slot memory.
// Remove, access and insert into a free slot need no search; find scans the slots from 0 until
// a match or the size; insert with shifting searches right of the position for a free slot, then
// left when none is free there, and moves each entry between that slot and the position by one.
// Next request taken the cycle after the result load, never while an item is in flight.
// Reset (rst, synchronous): slot valid bits cleared, count 0, size 16.
module gapped_slot_list #(
  parameter int SLOTS = 16
) (
  input logic       clk,
  input logic       rst,
  gsl_req_if.sink   req,
  gsl_rsp_if.source rsp,
  gsl_cfg_if.sink   cfg
);
  import gsl_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  // Size register accepts a transfer at any time; the user must write it only while idle, the block does not enforce it
  assign cfg.ready = 1'b1;

  // Controller: walks the insert search/shift, remove, access and find sequences
  gsl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: slot store, index walker, fill counter and response register
  gsl_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg.valid),
    .cfg_data           (cfg.data),
    .in_opcode          (req.opcode),
    .in_position        (req.position),
    .in_value           (req.value),
    .cmd                (cmd),
    .st                 (st),
    .out_valid          (rsp.valid),
    .out_ready          (rsp.ready),
    .out_ok             (rsp.ok),
    .out_read_value     (rsp.read_value),
    .out_found_position (rsp.found_position),
    .out_filled_count   (rsp.filled_count)
  );

`ifndef ASSERT_OFF
  // One item in flight: after a request transfer the block stays busy
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while an item is in flight");

  // Slot writes only happen while an item is being worked on
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> !req.ready)
    else $error("slot write while idle");

  // A failed operation reports no data
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ok |-> rsp.read_value == 8'd0 && rsp.found_position == 4'd0)
    else $error("failed result carries data");

  // The response register is only loaded when it is free
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !rsp.valid || rsp.ready)
    else $error("response overwritten before transfer");
`endif

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the gapped slot list: drives request transfers,
// predicts every response and checks each one on the response channel.
// Needs gsl_pkg (opcodes, reset size) and the channel interfaces in gsl_if.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gsl_pkg::*;

  localparam int NSLOT      = 16;
  localparam int DRAIN_CYC  = 8;        // idle cycles after the last response
  localparam int CYCLE_CAP  = 1000000;  // timeout in clock cycles
  localparam int QUEUE_AHEAD = 3;       // requests generated ahead of the predictor
  localparam int REPORT_MAX = 10;

  // One request and one response as the channels carry them
  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] position;
    logic [7:0] value;
  } list_op_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] read_value;
    logic [3:0] found_position;
    logic [4:0] filled_count;
  } list_res_t;

  logic clk;
  logic rst;

  gsl_req_if req_ch ();
  gsl_rsp_if rsp_ch ();
  gsl_cfg_if cfg_ch ();

  gapped_slot_list #(
    .SLOTS(NSLOT)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // Shadow of the list: slot bytes, filled counter and size register
  logic [7:0] slot_mem [NSLOT];
  int         fill_cnt;
  logic [4:0] size_reg;

  list_op_t  op_pending [$];   // requests waiting to be offered, front is on the bus
  list_res_t res_due [$];      // predicted responses, oldest first

  int  tx_idle_pct;
  int  rx_idle_pct;
  int  rx_hold_left;           // receiver hold-off, counted down in its own process
  int  err_cnt;
  int  cycle_cnt;
  logic req_xfer;              // request transfer seen at the last rising edge

  list_res_t got_res;
  list_res_t want_res;

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Register value clamped to 1..NSLOT
  function automatic int live_size();
    int sz;
    sz = int'(size_reg);
    if (sz < 1) sz = 1;
    if (sz > NSLOT) sz = NSLOT;
    return sz;
  endfunction

  // Insert with gap search: right side first, then left; entries slide
  // one place toward the free slot found.
  function automatic logic store_byte(input int pos, input logic [7:0] v, input int sz);
    int   gap;
    int   j;
    logic hit;
    if (v == 8'd0 || pos >= sz || fill_cnt >= sz) return 1'b0;
    if (slot_mem[pos] != 8'd0) begin
      hit = 1'b0;
      gap = 0;
      for (j = pos; j < sz; j++) begin
        if (!hit && slot_mem[j] == 8'd0) begin
          gap = j;
          hit = 1'b1;
        end
      end
      if (hit) begin
        for (j = gap; j > pos; j--) slot_mem[j] = slot_mem[j-1];
      end else begin
        for (j = pos; j >= 0; j--) begin
          if (!hit && slot_mem[j] == 8'd0) begin
            gap = j;
            hit = 1'b1;
          end
        end
        if (!hit) return 1'b0;  // every slot within the size is taken
        for (j = gap; j < pos; j++) slot_mem[j] = slot_mem[j+1];
      end
    end
    slot_mem[pos] = v;
    fill_cnt++;
    return 1'b1;
  endfunction

  function automatic list_res_t apply_list_op(input list_op_t o);
    list_res_t r;
    int        sz;
    int        pos;
    int        i;
    r   = '0;
    sz  = live_size();
    pos = int'(o.position);
    case (o.opcode)
      OP_INSERT: r.ok = store_byte(pos, o.value, sz);
      OP_REMOVE: begin
        if (pos < sz && slot_mem[pos] != 8'd0) begin
          slot_mem[pos] = 8'd0;
          if (fill_cnt > 0) fill_cnt--;  // never wraps below zero
          r.ok = 1'b1;
        end
      end
      OP_ACCESS: begin
        if (pos < sz && slot_mem[pos] != 8'd0) begin
          r.read_value = slot_mem[pos];
          r.ok = 1'b1;
        end
      end
      OP_FIND: begin
        // a search for zero finds the first empty slot
        for (i = 0; i < sz; i++) begin
          if (!r.ok && slot_mem[i] == o.value) begin
            r.ok = 1'b1;
            r.found_position = i[3:0];
          end
        end
      end
      default: ;
    endcase
    r.filled_count = fill_cnt[4:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: changes at the falling edge, holds until the transfer
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_xfer) void'(op_pending.pop_front());
      if (req_ch.valid && !req_xfer) begin
        // still waiting for ready: keep the offer as it is
      end else if (op_pending.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        req_ch.valid    <= 1'b1;
        req_ch.opcode   <= op_pending[0].opcode;
        req_ch.position <= op_pending[0].position;
        req_ch.value    <= op_pending[0].value;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response ready: random idling, forced low during a hold-off
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= (rx_hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(negedge clk) begin
    if (rx_hold_left != 0) rx_hold_left <= rx_hold_left - 1;
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples both channels at the rising edge. The response is
  // checked before a new request is predicted, so a response never meets
  // the expectation of the request taken at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    req_xfer <= !rst && req_ch.valid && req_ch.ready;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got_res.ok             = rsp_ch.ok;
      got_res.read_value     = rsp_ch.read_value;
      got_res.found_position = rsp_ch.found_position;
      got_res.filled_count   = rsp_ch.filled_count;
      if (res_due.size() == 0) begin
        err_cnt++;
        if (err_cnt <= REPORT_MAX)
          $display("%0t: response transfer with no request outstanding", $realtime);
      end else begin
        want_res = res_due.pop_front();
        if (got_res.ok !== want_res.ok || got_res.read_value !== want_res.read_value ||
            got_res.found_position !== want_res.found_position ||
            got_res.filled_count !== want_res.filled_count) begin
          err_cnt++;
          if (err_cnt <= REPORT_MAX)
            $display("%0t: bad response ok=%0d rd=%0d fp=%0d cnt=%0d, want %0d %0d %0d %0d",
                     $realtime, got_res.ok, got_res.read_value, got_res.found_position,
                     got_res.filled_count, want_res.ok, want_res.read_value,
                     want_res.found_position, want_res.filled_count);
        end
      end
    end
    if (!rst && req_ch.valid && req_ch.ready)
      res_due.push_back(apply_list_op(list_op_t'({req_ch.opcode, req_ch.position,
                                                  req_ch.value})));
  end

  // Timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_op(input logic [1:0] opc, input int pos, input int v);
    list_op_t o;
    o.opcode   = opc;
    o.position = pos[3:0];
    o.value    = v[7:0];
    op_pending.push_back(o);
  endtask

  // Wait until every request has been answered, then let the block go quiet
  task automatic settle();
    while (op_pending.size() != 0 || res_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // Size register write; only called with the block idle
  task automatic write_size(input logic [4:0] v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    size_reg = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic new_phase(input logic [4:0] sz, input int tx_pct, input int rx_pct);
    settle();
    write_size(sz);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // One random request, shaped by the shadow state: inserts thin out as the
  // list fills, removes and accesses mostly hit taken slots, finds often
  // look for a byte that is stored. About one in ten positions is anywhere.
  task automatic queue_random_op();
    int         sz;
    int         roll;
    int         ins_cut;
    int         pos;
    int         k;
    int         i;
    int         v;
    logic [1:0] opc;
    sz      = live_size();
    roll    = $urandom_range(0, 99);
    ins_cut = (fill_cnt * 2 < sz) ? 55 : ((fill_cnt < sz) ? 40 : 25);
    if (roll < ins_cut) opc = OP_INSERT;
    else if (roll < ins_cut + 25) opc = OP_REMOVE;
    else if (roll < ins_cut + 40) opc = OP_ACCESS;
    else opc = OP_FIND;

    pos = $urandom_range(0, sz - 1);
    if ($urandom_range(0, 9) == 0) begin
      pos = $urandom_range(0, NSLOT - 1);
    end else if ((opc == OP_REMOVE || opc == OP_ACCESS) && $urandom_range(0, 3) != 0) begin
      k = pos;
      for (i = sz - 1; i >= 0; i--)
        if (slot_mem[(k + i) % sz] != 8'd0) pos = (k + i) % sz;
    end

    v = $urandom_range(0, 255);
    if (opc == OP_INSERT) begin
      roll = $urandom_range(0, 19);
      if (roll == 0) v = 0;
      else if (roll < 12) v = $urandom_range(1, 12);
      else v = $urandom_range(1, 255);
    end else if (opc == OP_FIND) begin
      roll = $urandom_range(0, 3);
      if (roll < 2) v = slot_mem[$urandom_range(0, sz - 1)];
      else if (roll == 2) v = $urandom_range(1, 12);
    end
    queue_op(opc, pos, v);
  endtask

  // Random requests kept a few ahead of the predictor; optionally the
  // sender pauses halfway until every response is in.
  task automatic random_burst(input int n, input bit mid_pause);
    int i;
    for (i = 0; i < n; i++) begin
      if (mid_pause && i == n / 2) settle();
      while (op_pending.size() >= QUEUE_AHEAD) @(posedge clk);
      queue_random_op();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.opcode   = OP_INSERT;
    req_ch.position = '0;
    req_ch.value    = '0;
    rsp_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    req_xfer        = 1'b0;
    foreach (slot_mem[i]) slot_mem[i] = 8'd0;
    fill_cnt        = 0;
    size_reg        = SIZE_RESET;
    tx_idle_pct     = 11;
    rx_idle_pct     = 73;
    rx_hold_left    = 0;
    err_cnt         = 0;
    cycle_cnt       = 0;

    // reset held high from the start, released at a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty list, zero byte, both shift directions, full-width fields
    queue_op(OP_ACCESS, 0, 0);     // empty slot
    queue_op(OP_REMOVE, 0, 0);     // empty slot
    queue_op(OP_FIND, 0, 0);       // zero finds the first empty slot
    queue_op(OP_FIND, 0, 255);     // absent
    queue_op(OP_INSERT, 3, 0);     // zero cannot be stored
    queue_op(OP_INSERT, 15, 255);
    queue_op(OP_INSERT, 0, 1);
    queue_op(OP_INSERT, 0, 2);     // taken: slides right
    queue_op(OP_ACCESS, 0, 0);
    queue_op(OP_ACCESS, 1, 0);
    queue_op(OP_INSERT, 15, 3);    // taken, nothing free to the right: slides left
    queue_op(OP_FIND, 0, 255);
    queue_op(OP_FIND, 0, 3);
    queue_op(OP_REMOVE, 15, 0);
    queue_op(OP_REMOVE, 15, 0);
    queue_op(OP_ACCESS, 15, 0);
    queue_op(OP_INSERT, 15, 128);
    random_burst(250, 1'b0);

    // Small size, long receiver hold-off so the block backs up
    new_phase(5'd4, 11, 73);
    queue_op(OP_INSERT, 4, 9);     // position at the size
    queue_op(OP_ACCESS, 15, 0);    // beyond the size
    queue_op(OP_REMOVE, 5, 0);
    rx_hold_left = 400;
    random_burst(200, 1'b0);

    new_phase(5'd0, 11, 73);       // clamps to one slot
    random_burst(120, 1'b0);

    new_phase(5'd31, 73, 11);      // clamps to the full row
    random_burst(250, 1'b0);

    new_phase(5'd1, 73, 11);
    random_burst(100, 1'b0);

    new_phase(5'd9, 73, 11);
    random_burst(250, 1'b1);

    new_phase(5'd16, 0, 0);
    random_burst(250, 1'b0);

    new_phase(5'd17, 0, 0);
    random_burst(230, 1'b0);

    settle();
    if (err_cnt == 0 && res_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
